// ----- src/jtsp_pkg.sv -----
// ----------------------------------------------------------------------------
// jtsp_pkg
// Shared types, codes and character constants of the JSON token stream parser.
// ----------------------------------------------------------------------------
package jtsp_pkg;

	localparam int STACK_DEPTH_DEF   = 16;
	localparam int POSITION_BITS_DEF = 16;

	// Result queue between the scanner and the token channel
	localparam int OUT_FIFO_DEPTH = 4;
	localparam int OUT_PTR_W      = $clog2(OUT_FIFO_DEPTH);
	localparam int OUT_CNT_W      = OUT_PTR_W + 1;

	// Document characters the scanner reacts to
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NL     = 8'h0A;

	typedef enum logic [3:0] {
		MODE_OUT = 4'b0001,
		MODE_STR = 4'b0010,
		MODE_ESC = 4'b0100,
		MODE_NUM = 4'b1000
	} scan_mode_t;

	typedef enum logic [1:0] {
		MARK_NONE  = 2'd0,
		MARK_OBJ   = 2'd1,
		MARK_ARR   = 2'd2,
		MARK_COLON = 2'd3
	} mark_t;

	typedef enum logic [3:0] {
		KIND_OTHER  = 4'd0,
		KIND_LBRACE = 4'd1,
		KIND_RBRACE = 4'd2,
		KIND_LBRACK = 4'd3,
		KIND_RBRACK = 4'd4,
		KIND_COLON  = 4'd5,
		KIND_COMMA  = 4'd6,
		KIND_STRING = 4'd7,
		KIND_NAME   = 4'd8,
		KIND_NUMBER = 4'd9,
		KIND_ERROR  = 4'd10
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE         = 3'd0,
		ERR_SYNTAX       = 3'd1,
		ERR_BAD_ARR_END  = 3'd2,
		ERR_BAD_STRING   = 3'd3,
		ERR_BAD_ARRAY    = 3'd4,
		ERR_OVERFLOW     = 3'd5,
		ERR_UNTERMINATED = 3'd6
	} err_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_document;
	} in_item_t;

	typedef struct packed {
		kind_t       token_kind;
		err_t        error_code;
		logic [15:0] value_offset;
		logic [15:0] value_length;
		logic [4:0]  nest_depth;
		logic        last_of_run;
	} out_item_t;

	// Stack write request: push writes the mark at the current depth
	typedef struct packed {
		logic  push;
		mark_t mark;
	} stack_cmd_t;

	// Up to two tokens caused by one input beat, in order
	typedef struct packed {
		logic [1:0] count;
		out_item_t  first;
		out_item_t  second;
	} step_res_t;

endpackage

// ----- src/jtsp_stack.sv -----
// ----------------------------------------------------------------------------
// jtsp_stack
// Nesting stack memory with two registered read ports (top and next below).
// ----------------------------------------------------------------------------
module jtsp_stack import jtsp_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic [$clog2(STACK_DEPTH+1)-1:0] depth_q,
	input  logic [$clog2(STACK_DEPTH+1)-1:0] depth_next,
	input  stack_cmd_t                       cmd,
	output mark_t                            top_mark,
	output mark_t                            second_mark
);

	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	mark_t          mem [STACK_DEPTH];
	mark_t          top_q;
	mark_t          second_q;
	logic [DW-1:0]  top_idx;
	logic [DW-1:0]  second_idx;
	logic [AW-1:0]  wr_addr;
	logic [AW-1:0]  top_addr;
	logic [AW-1:0]  second_addr;

	// Read at the depth the next beat will see; entries below zero are never used
	assign top_idx     = depth_next - DW'(1);
	assign second_idx  = depth_next - DW'(2);
	assign wr_addr     = depth_q[AW-1:0];
	assign top_addr    = top_idx[AW-1:0];
	assign second_addr = second_idx[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_addr] <= cmd.mark;
		end
		// forward a mark written in the same cycle
		if (cmd.push && wr_addr == top_addr) begin
			top_q <= cmd.mark;
		end else begin
			top_q <= mem[top_addr];
		end
		if (cmd.push && wr_addr == second_addr) begin
			second_q <= cmd.mark;
		end else begin
			second_q <= mem[second_addr];
		end
	end

	assign top_mark    = top_q;
	assign second_mark = second_q;

endmodule

// ----- src/jtsp_step.sv -----
// ----------------------------------------------------------------------------
// jtsp_step
// Per-byte scanner: next scan state, stack request and up to two tokens.
// ----------------------------------------------------------------------------
module jtsp_step import jtsp_pkg::*; #(
	parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  in_item_t                         char_data,
	input  scan_mode_t                       mode_q,
	input  logic                             pending_q,
	input  logic                             is_name_q,
	input  logic [POSITION_BITS-1:0]         start_q,
	input  logic [POSITION_BITS-1:0]         len_q,
	input  logic [POSITION_BITS-1:0]         pos_q,
	input  logic [$clog2(STACK_DEPTH+1)-1:0] depth_q,
	input  mark_t                            top_mark,
	input  mark_t                            second_mark,
	output scan_mode_t                       mode_d,
	output logic                             pending_d,
	output logic                             is_name_d,
	output logic [POSITION_BITS-1:0]         start_d,
	output logic [POSITION_BITS-1:0]         len_d,
	output logic [POSITION_BITS-1:0]         pos_d,
	output logic [$clog2(STACK_DEPTH+1)-1:0] depth_d,
	output stack_cmd_t                       cmd,
	output step_res_t                        res
);

	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int PB = POSITION_BITS;
	localparam logic [PB-1:0] POS_MAX = '1;

	function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
		return (v == POS_MAX) ? v : v + 1'b1;
	endfunction

	function automatic logic [15:0] sat16(input logic [PB-1:0] v);
		logic [PB+15:0] ext;
		ext = {16'b0, v};
		return (|ext[PB+15:16]) ? 16'hFFFF : ext[15:0];
	endfunction

	function automatic logic [4:0] depth5(input logic [DW-1:0] d);
		logic [DW+4:0] ext;
		ext = {5'b0, d};
		return ext[4:0];
	endfunction

	function automatic out_item_t make_item(input kind_t k, input err_t e,
			input logic [PB-1:0] off, input logic [PB-1:0] len,
			input logic [DW-1:0] d);
		out_item_t it;
		it.token_kind   = k;
		it.error_code   = e;
		it.value_offset = sat16(off);
		it.value_length = sat16(len);
		it.nest_depth   = depth5(d);
		it.last_of_run  = 1'b0;
		return it;
	endfunction

	logic [7:0]    c;
	logic          is_digit;
	logic          room;
	mark_t         s;
	mark_t         s2;

	assign c        = char_data.data_byte;
	assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	assign room     = depth_q < DW'(STACK_DEPTH);
	assign s        = (depth_q != '0) ? top_mark : MARK_NONE;
	assign s2       = (depth_q > DW'(1)) ? second_mark : MARK_NONE;

	always_comb begin
		mark_t         s1;
		logic [DW-1:0] d1;
		logic          go_out;
		logic          v_a, v_b, v_c;
		out_item_t     e_a, e_b, e_c;

		mode_d    = mode_q;
		pending_d = pending_q;
		is_name_d = is_name_q;
		start_d   = start_q;
		len_d     = len_q;
		depth_d   = depth_q;
		cmd       = '0;
		go_out    = 1'b0;
		v_a = 1'b0; v_b = 1'b0; v_c = 1'b0;
		e_a = '0;   e_b = '0;   e_c = '0;
		s1  = s;
		d1  = depth_q;

		unique case (mode_q)
			MODE_NUM: begin
				if (is_digit || c == CH_DOT) begin
					len_d = sat_inc(len_q);
				end else begin
					v_a    = 1'b1;
					e_a    = make_item(KIND_NUMBER, ERR_NONE, start_q, len_q, depth_q);
					mode_d = MODE_OUT;
					go_out = 1'b1;
				end
			end
			MODE_STR: begin
				if (c == CH_QUOTE) begin
					v_a    = 1'b1;
					e_a    = make_item(is_name_q ? KIND_NAME : KIND_STRING, ERR_NONE,
						start_q, len_q, depth_q);
					mode_d = MODE_OUT;
				end else begin
					len_d = sat_inc(len_q);
					if (c == CH_BSLASH) begin
						mode_d = MODE_ESC;
					end
				end
			end
			MODE_ESC: begin
				len_d  = sat_inc(len_q);
				mode_d = MODE_STR;
			end
			MODE_OUT: begin
				go_out = 1'b1;
			end
			default: begin
				mode_d = MODE_OUT;
			end
		endcase

		if (go_out) begin
			unique case (c)
				CH_SPACE, CH_NL: begin
				end
				CH_LBRACE, CH_COLON: begin
					v_b = 1'b1;
					if (room) begin
						cmd.push  = 1'b1;
						cmd.mark  = (c == CH_LBRACE) ? MARK_OBJ : MARK_COLON;
						depth_d   = depth_q + 1'b1;
						pending_d = 1'b0;
						e_b = make_item((c == CH_LBRACE) ? KIND_LBRACE : KIND_COLON,
							ERR_NONE, '0, '0, depth_d);
					end else begin
						e_b = make_item(KIND_ERROR, ERR_OVERFLOW, '0, '0, depth_q);
					end
				end
				CH_RBRACE: begin
					v_b = 1'b1;
					// a value closes its pair first
					if (s == MARK_COLON && pending_q) begin
						d1 = depth_q - 1'b1;
						s1 = s2;
					end
					if (s1 == MARK_OBJ) begin
						depth_d = d1 - 1'b1;
						e_b = make_item(KIND_RBRACE, ERR_NONE, '0, '0, depth_d);
					end else begin
						depth_d = d1;
						e_b = make_item(KIND_ERROR, ERR_SYNTAX, '0, '0, d1);
					end
				end
				CH_RBRACK: begin
					v_b = 1'b1;
					if (s == MARK_ARR) begin
						depth_d = depth_q - 1'b1;
						e_b = make_item(KIND_RBRACK, ERR_NONE, '0, '0, depth_d);
					end else begin
						e_b = make_item(KIND_ERROR, ERR_BAD_ARR_END, '0, '0, depth_q);
					end
				end
				CH_COMMA: begin
					v_b = 1'b1;
					if (s == MARK_COLON && pending_q) begin
						depth_d = depth_q - 1'b1;
						e_b = make_item(KIND_COMMA, ERR_NONE, '0, '0, depth_d);
					end else if (s == MARK_ARR) begin
						e_b = make_item(KIND_COMMA, ERR_NONE, '0, '0, depth_q);
					end else begin
						e_b = make_item(KIND_ERROR, ERR_SYNTAX, '0, '0, depth_q);
					end
				end
				CH_QUOTE: begin
					if (s != MARK_NONE) begin
						is_name_d = (s == MARK_OBJ);
						pending_d = 1'b1;
						start_d   = sat_inc(pos_q);
						len_d     = '0;
						mode_d    = MODE_STR;
					end else begin
						v_b = 1'b1;
						e_b = make_item(KIND_ERROR, ERR_BAD_STRING, '0, '0, depth_q);
					end
				end
				CH_LBRACK: begin
					v_b = 1'b1;
					if (s == MARK_NONE) begin
						e_b = make_item(KIND_ERROR, ERR_BAD_ARRAY, '0, '0, depth_q);
					end else if (room) begin
						cmd.push  = 1'b1;
						cmd.mark  = MARK_ARR;
						depth_d   = depth_q + 1'b1;
						pending_d = 1'b0;
						e_b = make_item(KIND_LBRACK, ERR_NONE, '0, '0, depth_d);
					end else begin
						e_b = make_item(KIND_ERROR, ERR_OVERFLOW, '0, '0, depth_q);
					end
				end
				default: begin
					if ((s == MARK_COLON || s == MARK_ARR) && is_digit) begin
						pending_d = 1'b1;
						start_d   = pos_q;
						len_d     = PB'(1);
						mode_d    = MODE_NUM;
					end else begin
						v_b = 1'b1;
						e_b = make_item(KIND_OTHER, ERR_NONE, '0, '0, depth_q);
					end
				end
			endcase
		end

		pos_d = sat_inc(pos_q);

		if (char_data.end_of_document) begin
			if (mode_d == MODE_NUM) begin
				v_c = 1'b1;
				e_c = make_item(KIND_NUMBER, ERR_NONE, start_d, len_d, depth_d);
			end else if (mode_d == MODE_STR || mode_d == MODE_ESC) begin
				v_c = 1'b1;
				e_c = make_item(KIND_ERROR, ERR_UNTERMINATED, start_d, len_d, depth_d);
			end
			mode_d    = MODE_OUT;
			pending_d = 1'b0;
			is_name_d = 1'b0;
			start_d   = '0;
			len_d     = '0;
			pos_d     = '0;
			depth_d   = '0;
		end

		// pack the tokens in order; at most two are ever present
		res = '0;
		priority if (v_a) begin
			res.first = e_a;
			if (v_b) begin
				res.second = e_b;
				res.count  = 2'd2;
			end else if (v_c) begin
				res.second = e_c;
				res.count  = 2'd2;
			end else begin
				res.count = 2'd1;
			end
		end else if (v_b) begin
			res.first = e_b;
			if (v_c) begin
				res.second = e_c;
				res.count  = 2'd2;
			end else begin
				res.count = 2'd1;
			end
		end else if (v_c) begin
			res.first = e_c;
			res.count = 2'd1;
		end else begin
			res.count = 2'd0;
		end
		if (res.count == 2'd2) begin
			res.second.last_of_run = 1'b1;
		end else if (res.count == 2'd1) begin
			res.first.last_of_run = 1'b1;
		end
	end

endmodule

// ----- src/jtsp_out_fifo.sv -----
// ----------------------------------------------------------------------------
// jtsp_out_fifo
// Token queue: takes up to two tokens per cycle, hands out one per beat.
// ----------------------------------------------------------------------------
module jtsp_out_fifo import jtsp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic [1:0] wr_count,
	input  out_item_t wr_first,
	input  out_item_t wr_second,
	output logic      room_for_two,
	output logic      token_valid,
	input  logic      token_ready,
	output out_item_t token_data
);

	out_item_t              mem [OUT_FIFO_DEPTH];
	logic [OUT_PTR_W-1:0]   wr_ptr_q;
	logic [OUT_PTR_W-1:0]   rd_ptr_q;
	logic [OUT_CNT_W-1:0]   count_q;
	logic [OUT_PTR_W-1:0]   wr_ptr_nx;
	logic                   pop;

	assign wr_ptr_nx    = wr_ptr_q + 1'b1;
	assign pop          = token_valid && token_ready;
	assign token_valid  = count_q != '0;
	assign token_data   = mem[rd_ptr_q];
	assign room_for_two = count_q <= OUT_CNT_W'(OUT_FIFO_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (wr_count != 2'd0) begin
			mem[wr_ptr_q] <= wr_first;
		end
		if (wr_count == 2'd2) begin
			mem[wr_ptr_nx] <= wr_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(wr_count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + OUT_CNT_W'(wr_count) - OUT_CNT_W'(pop);
		end
	end

endmodule

// ----- src/json_token_stream_parser.sv -----
// ----------------------------------------------------------------------------
// json_token_stream_parser: streaming JSON tokenizer with a nesting stack memory
// Ordering: tokens enter the token queue when their byte beat is taken and leave in order.
// Throughput: one byte per cycle while the queue has room for two tokens; a byte with two tokens costs two token beats.
// Reset: arst_n clears scan state, depth and the token queue; stack RAM is not cleared.
// ----------------------------------------------------------------------------
module json_token_stream_parser import jtsp_pkg::*; #(
	parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      char_valid,
	output logic      char_ready,
	input  in_item_t  char_data,
	output logic      token_valid,
	input  logic      token_ready,
	output out_item_t token_data
);

	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int PB = POSITION_BITS;

	// Scan state registers: mode, pending value, name flag, value window,
	// stream position and stack depth. The stack marks live in the RAM.
	scan_mode_t     mode_q;
	logic           pending_q;
	logic           is_name_q;
	logic [PB-1:0]  start_q;
	logic [PB-1:0]  len_q;
	logic [PB-1:0]  pos_q;
	logic [DW-1:0]  depth_q;

	scan_mode_t     mode_d;
	logic           pending_d;
	logic           is_name_d;
	logic [PB-1:0]  start_d;
	logic [PB-1:0]  len_d;
	logic [PB-1:0]  pos_d;
	logic [DW-1:0]  depth_d;
	logic [DW-1:0]  depth_next;

	mark_t          top_mark;
	mark_t          second_mark;
	stack_cmd_t     step_cmd;
	stack_cmd_t     ram_cmd;
	step_res_t      step_res;
	logic           char_accept;
	logic           room_for_two;
	logic [1:0]     wr_count;

	// Take a byte whenever the token queue can absorb the worst case of two
	// tokens. The queue decouples both sides, so a waiting token does not stall
	// input until the queue nears full.
	assign char_ready  = room_for_two;
	assign char_accept = char_valid && char_ready;

	// Scanner: pure decode of the current byte against the registered state
	// and the registered top two stack marks.
	jtsp_step #(
		.STACK_DEPTH   (STACK_DEPTH),
		.POSITION_BITS (POSITION_BITS)
	) u_step (
		.char_data   (char_data),
		.mode_q      (mode_q),
		.pending_q   (pending_q),
		.is_name_q   (is_name_q),
		.start_q     (start_q),
		.len_q       (len_q),
		.pos_q       (pos_q),
		.depth_q     (depth_q),
		.top_mark    (top_mark),
		.second_mark (second_mark),
		.mode_d      (mode_d),
		.pending_d   (pending_d),
		.is_name_d   (is_name_d),
		.start_d     (start_d),
		.len_d       (len_d),
		.pos_d       (pos_d),
		.depth_d     (depth_d),
		.cmd         (step_cmd),
		.res         (step_res)
	);

	// Only write the stack on an accepted beat. The RAM reads the top two
	// entries at the depth that the next beat will see, so their registered
	// data lines up with depth_q on the following cycle; a push into the
	// entry being read is forwarded inside the stack.
	always_comb begin
		ram_cmd      = step_cmd;
		ram_cmd.push = step_cmd.push && char_accept;
	end
	assign depth_next = char_accept ? depth_d : depth_q;

	jtsp_stack #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_stack (
		.clk         (clk),
		.depth_q     (depth_q),
		.depth_next  (depth_next),
		.cmd         (ram_cmd),
		.top_mark    (top_mark),
		.second_mark (second_mark)
	);

	// Advance scan state on every accepted beat; hold otherwise.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_OUT;
			pending_q <= 1'b0;
			is_name_q <= 1'b0;
			start_q   <= '0;
			len_q     <= '0;
			pos_q     <= '0;
			depth_q   <= '0;
		end else if (char_accept) begin
			mode_q    <= mode_d;
			pending_q <= pending_d;
			is_name_q <= is_name_d;
			start_q   <= start_d;
			len_q     <= len_d;
			pos_q     <= pos_d;
			depth_q   <= depth_d;
		end
	end

	// Drop the tokens of a byte into the queue only when its beat is taken.
	assign wr_count = char_accept ? step_res.count : 2'd0;

	jtsp_out_fifo u_out_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_count     (wr_count),
		.wr_first     (step_res.first),
		.wr_second    (step_res.second),
		.room_for_two (room_for_two),
		.token_valid  (token_valid),
		.token_ready  (token_ready),
		.token_data   (token_data)
	);

	// The stack never grows past its capacity.
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(STACK_DEPTH))
		else $error("nest depth beyond stack capacity");

	// The final byte of a document leaves the scanner in its reset state.
	a_eod_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(char_accept && char_data.end_of_document) |=>
		(depth_q == '0 && mode_q == MODE_OUT && pending_q == 1'b0 && pos_q == '0))
		else $error("scanner state not cleared after end of document");

	// A beat that produces tokens makes the token channel valid next cycle.
	a_token_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(char_accept && step_res.count != 2'd0) |=> token_valid)
		else $error("tokens of an accepted byte were not queued");

endmodule
